// ----- design/swp2p_pkg.sv -----
package swp2p_pkg;

	localparam int HALF_WINDOW_BITS  = 9;
	localparam int HALF_WINDOW_RESET = 100;
	localparam int RING_DEPTH_DEF    = 1024;
	localparam int SAMPLE_BITS_DEF   = 16;

	// controller -> datapath
	typedef struct packed {
		logic accept;      // latch request sample, clear rescan flag
		logic back_fill;   // walk pointer <= fill count
		logic back_len_m1; // walk pointer <= window length - 1
		logic back_dec;    // walk pointer - 1
		logic rd_issue;    // read ring at walk pointer
		logic rd_drop;     // read belongs to the drop phase
		logic fill_trim;   // fill count <= window length - 1
		logic scan_init;   // rescan extremes <= reset values
		logic finish;      // store sample, merge it into extremes
		logic out_load;    // load result registers
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;        // fill count >= window length
		logic back_at_len; // walk pointer on the last sample to drop
		logic back_is_one; // walk pointer on the newest stored sample
		logic len_m1_zero; // window of one sample
		logic need;        // a dropped sample was a kept extreme
	} dp_status_t;

endpackage

// ----- design/sliding_window_peak_to_peak.sv -----
// Each accepted request runs in order: a drop phase that reads each sample leaving the window
// (only if the window is full), a rescan of the L - 1 remaining samples (L = window length)
// only if a dropped sample was a kept extreme, then the store and merge, then the result load.
// The ring is read one sample per cycle; a new request waits until the last result is loaded.
// Reset (arst_n low): empty window, extremes at their limits, half_window = 100, no output.
module sliding_window_peak_to_peak
	import swp2p_pkg::*;
#(
	parameter int RING_DEPTH  = RING_DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: half window length
	input  logic                          cfg_we,
	input  logic [HALF_WINDOW_BITS-1:0]   cfg_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	output logic signed [SAMPLE_BITS-1:0] window_min,
	output logic [SAMPLE_BITS-1:0]        swing,
	output logic signed [SAMPLE_BITS-1:0] midpoint
);

	// The controller sequences each request: drop samples that leave the window
	// (checking each against the kept extremes), rescan the survivors only if an
	// extreme left, then store the new sample and merge it into the extremes.
	// The result register lets a new request in while a result waits.
	dp_cmd_t    cmd;
	dp_status_t status;

	swp2p_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Ring memory, window length, extremes and result arithmetic.
	swp2p_datapath #(
		.RING_DEPTH  (RING_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.cmd        (cmd),
		.status     (status),
		.window_max (window_max),
		.window_min (window_min),
		.swing      (swing),
		.midpoint   (midpoint)
	);

endmodule

// ----- design/swp2p_datapath.sv -----
module swp2p_datapath
	import swp2p_pkg::*;
#(
	parameter int RING_DEPTH  = RING_DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [HALF_WINDOW_BITS-1:0]   cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  dp_cmd_t                       cmd,
	output dp_status_t                    status,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	output logic signed [SAMPLE_BITS-1:0] window_min,
	output logic [SAMPLE_BITS-1:0]        swing,
	output logic signed [SAMPLE_BITS-1:0] midpoint
);

	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int LW = (CW > HALF_WINDOW_BITS + 1) ? CW : HALF_WINDOW_BITS + 1;
	localparam int S  = SAMPLE_BITS;

	localparam logic signed [S-1:0] SMIN = {1'b1, {(S-1){1'b0}}};
	localparam logic signed [S-1:0] SMAX = {1'b0, {(S-1){1'b1}}};

	logic [HALF_WINDOW_BITS-1:0] half_window_q;
	logic signed [S-1:0]         sample_q;
	logic [AW-1:0]               wp_q;
	logic [CW-1:0]               fill_q;
	logic [CW-1:0]               back_q;
	logic signed [S-1:0]         cur_max_q, cur_min_q;
	logic signed [S-1:0]         scan_max_q, scan_min_q;
	logic                        need_q;
	logic                        rd_v_s1, rd_drop_s1;
	logic signed [S-1:0]         rd_data_s1;
	logic signed [S-1:0]         ring_mem [RING_DEPTH];

	logic [LW-1:0]       len_full, len_cap;
	logic [CW-1:0]       len_c, len_m1;
	logic [CW:0]         diff, idx;
	logic [AW-1:0]       rd_addr;
	logic                drop_hit;
	logic signed [S-1:0] base_max, base_min, new_max, new_min;
	logic [S-1:0]        pp_w;
	logic signed [S-1:0] mid_w;

	// window length, capped at the ring size
	assign len_full = LW'({half_window_q, 1'b1});
	assign len_cap  = (len_full > LW'(RING_DEPTH)) ? LW'(RING_DEPTH) : len_full;
	assign len_c    = len_cap[CW-1:0];
	assign len_m1   = len_c - CW'(1);

	// slot of the sample back_q places behind the write pointer
	assign diff    = (CW+1)'(wp_q) - (CW+1)'(back_q);
	assign idx     = diff[CW] ? diff + (CW+1)'(RING_DEPTH) : diff;
	assign rd_addr = idx[AW-1:0];

	assign drop_hit = rd_v_s1 && rd_drop_s1 &&
		(rd_data_s1 == cur_max_q || rd_data_s1 == cur_min_q);

	assign status.full        = fill_q >= len_c;
	assign status.back_at_len = back_q == len_c;
	assign status.back_is_one = back_q == CW'(1);
	assign status.len_m1_zero = len_m1 == '0;
	assign status.need        = need_q | drop_hit;

	assign base_max = need_q ? scan_max_q : cur_max_q;
	assign base_min = need_q ? scan_min_q : cur_min_q;
	assign new_max  = (sample_q > base_max) ? sample_q : base_max;
	assign new_min  = (sample_q < base_min) ? sample_q : base_min;

	assign pp_w  = S'(cur_max_q - cur_min_q);
	assign mid_w = cur_min_q + $signed({1'b0, pp_w[S-1:1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window_q <= HALF_WINDOW_BITS'(HALF_WINDOW_RESET);
			wp_q          <= '0;
			fill_q        <= '0;
			back_q        <= '0;
			cur_max_q     <= SMIN;
			cur_min_q     <= SMAX;
			need_q        <= 1'b0;
			rd_v_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				half_window_q <= cfg_data;
			end
			rd_v_s1 <= cmd.rd_issue;
			if (cmd.accept) begin
				need_q <= 1'b0;
			end else if (drop_hit) begin
				need_q <= 1'b1;
			end
			if (cmd.back_fill) begin
				back_q <= fill_q;
			end else if (cmd.back_len_m1) begin
				back_q <= len_m1;
			end else if (cmd.back_dec) begin
				back_q <= back_q - CW'(1);
			end
			if (cmd.fill_trim) begin
				fill_q <= len_m1;
			end else if (cmd.finish) begin
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.finish) begin
				wp_q      <= (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + AW'(1);
				cur_max_q <= new_max;
				cur_min_q <= new_min;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_drop_s1 <= cmd.rd_drop;
		if (cmd.accept) begin
			sample_q <= sample;
		end
		if (cmd.scan_init) begin
			scan_max_q <= SMIN;
			scan_min_q <= SMAX;
		end else if (rd_v_s1 && !rd_drop_s1) begin
			if (rd_data_s1 > scan_max_q) begin
				scan_max_q <= rd_data_s1;
			end
			if (rd_data_s1 < scan_min_q) begin
				scan_min_q <= rd_data_s1;
			end
		end
		if (cmd.out_load) begin
			window_max <= cur_max_q;
			window_min <= cur_min_q;
			swing      <= pp_w;
			midpoint   <= mid_w;
		end
	end

	// sample ring: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			ring_mem[wp_q] <= sample_q;
		end
		if (cmd.rd_issue) begin
			rd_data_s1 <= ring_mem[rd_addr];
		end
	end

endmodule

// ----- design/swp2p_ctrl.sv -----
module swp2p_ctrl
	import swp2p_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_DROP      = 7'b0000010,
		ST_DROP_WAIT = 7'b0000100,
		ST_SCAN      = 7'b0001000,
		ST_SCAN_WAIT = 7'b0010000,
		ST_FINISH    = 7'b0100000,
		ST_OUT       = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   load;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign load      = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.full) begin
						cmd.back_fill = 1'b1;
						state_d       = ST_DROP;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_DROP: begin
				cmd.rd_issue = 1'b1;
				cmd.rd_drop  = 1'b1;
				if (status.back_at_len) begin
					state_d = ST_DROP_WAIT;
				end else begin
					cmd.back_dec = 1'b1;
				end
			end
			ST_DROP_WAIT: begin
				cmd.fill_trim = 1'b1;
				if (status.need) begin
					cmd.scan_init   = 1'b1;
					cmd.back_len_m1 = 1'b1;
					state_d = status.len_m1_zero ? ST_SCAN_WAIT : ST_SCAN;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SCAN: begin
				cmd.rd_issue = 1'b1;
				if (status.back_is_one) begin
					state_d = ST_SCAN_WAIT;
				end else begin
					cmd.back_dec = 1'b1;
				end
			end
			ST_SCAN_WAIT: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (load) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- verif/tb_sliding_window_peak_to_peak.sv -----
module tb_sliding_window_peak_to_peak;
	import swp2p_pkg::*;

	localparam int SB             = SAMPLE_BITS_DEF;
	localparam int DEPTH          = RING_DEPTH_DEF;
	localparam int IDX_BITS       = $clog2(DEPTH);
	localparam int SAMPLE_MAX     = (1 << (SB - 1)) - 1;
	localparam int SAMPLE_MIN     = -(1 << (SB - 1));
	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 8;
	// worst request is a full-ring rescan plus stalls on both
	// sides; the bound below is several times that for every request of the run
	localparam int TIMEOUT_CYCLES = 4_000_000;
	localparam int MAX_REPORTS    = 10;
	localparam int TARGET_SAMPLES = 580;
	// block is idle once its result is out; spare cycles before any register write
	localparam int SETTLE_CYCLES  = 8;

	// one result: all fields kept as raw bit patterns
	typedef struct packed {
		logic [SB-1:0] wmax;
		logic [SB-1:0] wmin;
		logic [SB-1:0] p2p;
		logic [SB-1:0] mid;
	} window_stats_t;

	typedef enum int {
		PAT_FULL,      // any value
		PAT_NARROW,    // few distinct values, lots of duplicate extremes
		PAT_RAMP_UP,   // oldest sample is the minimum, forces rescans
		PAT_RAMP_DOWN, // oldest sample is the maximum
		PAT_EDGES      // values at the ends of the range
	} sample_pattern_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [HALF_WINDOW_BITS-1:0]   cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [SB-1:0]          sample;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [SB-1:0]          window_max;
	logic signed [SB-1:0]          window_min;
	logic [SB-1:0]                 swing;
	logic signed [SB-1:0]          midpoint;

	// ---------------------------------------------------------------------
	// Mirror of the block state, advanced once per accepted request
	// ---------------------------------------------------------------------
	logic signed [SB-1:0]        ring_mirror [DEPTH];
	int unsigned                 wr_slot   = 0;
	int unsigned                 fill_cnt  = 0;
	int                          trk_max   = SAMPLE_MIN;
	int                          trk_min   = SAMPLE_MAX;
	logic [HALF_WINDOW_BITS-1:0] hw_mirror = HALF_WINDOW_BITS'(HALF_WINDOW_RESET);

	window_stats_t expected_stats [$];
	int            mismatch_cnt = 0;
	int            samples_sent = 0;

	// stimulus shaping
	bit                   tx_quiet = 1'b0; // sender never idles (read by the sending process only)
	logic                 rx_quiet = 1'b0; // receiver always ready
	logic                 rx_hold  = 1'b0; // receiver held off for a long stretch
	logic signed [SB-1:0] ramp_val = '0;
	int                   narrow_base = 0;

	sliding_window_peak_to_peak i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.window_max (window_max),
		.window_min (window_min),
		.swing      (swing),
		.midpoint   (midpoint)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Advance the mirror by one sample and return the result it must produce.
	// Drops happen first (all surplus samples at once after a shrink), a rescan
	// runs if any dropped sample equals a kept extreme, then the new sample
	// is stored and merged.
	function automatic window_stats_t predict_window(logic signed [SB-1:0] s);
		int unsigned   win_len;
		int            v;
		int            k;
		int            p2p;
		bit            rescan_needed;
		window_stats_t r;
		win_len = 2 * hw_mirror + 1;
		if (win_len > DEPTH)
			win_len = DEPTH;
		rescan_needed = 1'b0;
		if (fill_cnt >= win_len) begin
			while (fill_cnt > win_len - 1) begin
				v = int'(ring_mirror[IDX_BITS'((wr_slot + DEPTH - fill_cnt) % DEPTH)]);
				if (v == trk_max || v == trk_min)
					rescan_needed = 1'b1;
				fill_cnt--;
			end
			if (rescan_needed) begin
				// empty window leaves the extremes at their reset limits
				trk_max = SAMPLE_MIN;
				trk_min = SAMPLE_MAX;
				for (k = fill_cnt; k > 0; k--) begin
					v = int'(ring_mirror[IDX_BITS'((wr_slot + DEPTH - k) % DEPTH)]);
					if (v > trk_max)
						trk_max = v;
					if (v < trk_min)
						trk_min = v;
				end
			end
		end
		ring_mirror[IDX_BITS'(wr_slot)] = s;
		wr_slot = (wr_slot + 1 >= DEPTH) ? 0 : wr_slot + 1;
		fill_cnt++;
		if (int'(s) > trk_max)
			trk_max = int'(s);
		if (int'(s) < trk_min)
			trk_min = int'(s);
		// difference is never negative, so division rounds down
		p2p    = trk_max - trk_min;
		r.wmax = SB'(trk_max);
		r.wmin = SB'(trk_min);
		r.p2p  = SB'(p2p);
		r.mid  = SB'(trk_min + p2p / 2);
		return r;
	endfunction

	function automatic void note_failure(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	function automatic void check_field(string name, logic [SB-1:0] exp_v, logic [SB-1:0] act_v);
		if (act_v !== exp_v)
			note_failure($sformatf("%s mismatch: expected %h, got %h", name, exp_v, act_v));
	endfunction

	// Gap length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int tx_gap();
		if (tx_quiet || $urandom_range(0, 1) == 0)
			return 0;
		return pick_gap();
	endfunction

	function automatic logic signed [SB-1:0] gen_sample(sample_pattern_t pat);
		case (pat)
			PAT_NARROW: begin
				return SB'(narrow_base + $urandom_range(0, 3));
			end
			PAT_RAMP_UP: begin
				ramp_val = ramp_val + SB'($urandom_range(1, 400));
				return ramp_val;
			end
			PAT_RAMP_DOWN: begin
				ramp_val = ramp_val - SB'($urandom_range(1, 400));
				return ramp_val;
			end
			PAT_EDGES: begin
				case ($urandom_range(0, 5))
					0: return SB'(SAMPLE_MIN);
					1: return SB'(SAMPLE_MAX);
					2: return SB'(SAMPLE_MIN + 1);
					3: return SB'(SAMPLE_MAX - 1);
					4: return '0;
					default: return '1;
				endcase
			end
			default: begin
				return SB'($urandom);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Request side: present one sample, hold it until accepted, then record
	// the expected result. With a zero gap valid stays high for the next
	// request, so valid is never dropped and raised in the same step.
	// ---------------------------------------------------------------------
	task automatic send_sample(logic signed [SB-1:0] s);
		int gap;
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_stats.push_back(predict_window(s));
		samples_sent++;
		gap = tx_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_burst(int count, sample_pattern_t pat);
		repeat (count) send_sample(gen_sample(pat));
	endtask

	// Stop offering requests and wait for every outstanding result.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_stats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called with the block idle.
	task automatic set_half_window(logic [HALF_WINDOW_BITS-1:0] hw);
		cfg_we   <= 1'b1;
		cfg_data <= hw;
		@(posedge clk);
		cfg_we    <= 1'b0;
		hw_mirror = hw;
	endtask

	function automatic sample_pattern_t pick_pattern();
		case ($urandom_range(0, 9)) inside
			[0:2]:   return PAT_FULL;
			[3:4]:   return PAT_NARROW;
			[5:6]:   return PAT_RAMP_UP;
			[7:8]:   return PAT_RAMP_DOWN;
			default: return PAT_EDGES;
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Range ends, one-sample window, duplicate extremes in a short window.
	task automatic test_directed();
		// reset window (half 100): extremes give full-scale swing
		send_sample(SB'(SAMPLE_MIN));
		send_sample(SB'(SAMPLE_MAX));
		send_sample('0);
		send_sample('1);
		send_sample(SB'(1));
		send_sample(SB'(16'h5555));
		send_sample(SB'(16'haaaa));
		wait_drained();
		// zero half window: first request drops everything, then each
		// sample stands alone (rescan of an empty window)
		set_half_window('0);
		send_sample(SB'(123));
		send_sample(SB'(SAMPLE_MIN));
		send_sample(SB'(SAMPLE_MAX));
		send_sample('0);
		wait_drained();
		// three-sample window with repeated extremes leaving it
		set_half_window(HALF_WINDOW_BITS'(1));
		send_sample(SB'(5));
		send_sample(SB'(5));
		send_sample(SB'(-3));
		send_sample(SB'(5));
		send_sample(SB'(-3));
		send_sample(SB'(-3));
		send_sample(SB'(7));
		send_sample(SB'(7));
		wait_drained();
	endtask

	// Largest window, then a shrink that drops most of the stored samples in one
	// request, then growth where nothing drops until the window refills.
	task automatic test_window_resize();
		set_half_window('1);
		repeat (4) send_burst(50, pick_pattern());
		wait_drained();
		set_half_window(HALF_WINDOW_BITS'(3));
		send_burst(30, PAT_RAMP_UP);
		wait_drained();
		set_half_window(HALF_WINDOW_BITS'(20));
		narrow_base = $urandom_range(0, 2000) - 1000;
		send_burst(25, PAT_NARROW);
		send_burst(25, PAT_FULL);
		wait_drained();
	endtask

	// Receiver held off while the sender keeps offering requests, so the
	// block backs up into its input. Afterwards the sender pauses until all
	// results are in before going on.
	task automatic test_backpressure();
		set_half_window(HALF_WINDOW_BITS'(4));
		tx_quiet = 1'b1;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (300) @(posedge clk);
				rx_hold <= 1'b0;
			end
			send_burst(40, PAT_RAMP_DOWN);
		join
		tx_quiet = 1'b0;
		wait_drained();
		send_burst(20, PAT_FULL);
		wait_drained();
	endtask

	// Random phases: mostly small windows, random content and idling.
	task automatic test_random_phases();
		int hw;
		int sel;
		bit quiet;
		while (samples_sent < TARGET_SAMPLES) begin
			sel = $urandom_range(0, 9);
			case (sel) inside
				0:       hw = 0;
				1:       hw = 1;
				[2:6]:   hw = $urandom_range(1, 8);
				[7:8]:   hw = $urandom_range(9, 40);
				default: hw = $urandom_range(41, 120);
			endcase
			set_half_window(HALF_WINDOW_BITS'(hw));
			// some phases run with no idling on either side
			quiet       = ($urandom_range(0, 4) == 0);
			tx_quiet    = quiet;
			rx_quiet   <= quiet;
			narrow_base = $urandom_range(0, 60000) - 30000;
			repeat ($urandom_range(1, 3)) send_burst($urandom_range(8, 20), pick_pattern());
			wait_drained();
		end
		tx_quiet  = 1'b0;
		rx_quiet <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Result side: random ready with short and occasional long stalls
	// ---------------------------------------------------------------------
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold)
				out_ready <= 1'b0;
			else if (rx_quiet)
				out_ready <= 1'b1;
			else begin
				if (stall_left == 0 && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
				if (stall_left > 0) begin
					out_ready <= 1'b0;
					stall_left--;
				end else
					out_ready <= 1'b1;
			end
		end
	end

	// Every accepted result is matched against the oldest expectation.
	initial begin : result_check
		window_stats_t exp_r;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_stats.size() == 0)
					note_failure($sformatf("result with no request pending: max %h min %h",
						window_max, window_min));
				else begin
					exp_r = expected_stats.pop_front();
					check_field("window_max", exp_r.wmax, window_max);
					check_field("window_min", exp_r.wmin, window_min);
					check_field("swing", exp_r.p2p, swing);
					check_field("midpoint", exp_r.mid, midpoint);
				end
			end
		end
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample   = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_window_resize();
		test_backpressure();
		test_random_phases();

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0 && expected_stats.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
